@@ design/esld_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the event stream line decoder.
// No dependencies; every file of the block but esld_ifs refers to it by scoped names.

package esld_pkg;

   localparam int NAME_MAX_DEF   = 16;
   localparam int NAME_MAX_LIMIT = 62;
   localparam int NLEN_W         = $clog2(NAME_MAX_LIMIT + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   // dispatches in flight: queue entries plus the one in the back end
   localparam int DCNT_W      = $clog2(QUEUE_DEPTH + 2);

   typedef enum logic {
      IN_BYTE = 1'b0,
      IN_EOS  = 1'b1
   } in_kind_type;

   typedef enum logic [1:0] {
      OUT_DATA = 2'd0,
      OUT_NAME = 2'd1,
      OUT_END  = 2'd2
   } out_kind_type;

   // work handed from the front end to the back end for one transaction
   typedef struct packed {
      logic              d0_vld;
      logic [7:0]        d0;
      logic              d1_vld;
      logic [7:0]        d1;
      logic              disp;
      logic [NLEN_W-1:0] dlen;
      logic              dovf;
   } cmd_type;

   // name store write port
   typedef struct packed {
      logic              vld;
      logic [NLEN_W-1:0] addr;
      logic [7:0]        data;
   } wr_type;

endpackage

@@ design/esld_ifs.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response transactions.
// Depends on nothing; used by the top level and its environment.

interface esld_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] byte_in;

   modport source (output valid, output kind, output byte_in, input ready);
   modport sink   (input valid, input kind, input byte_in, output ready);
endinterface

interface esld_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] out_kind;
   logic [7:0] out_byte;
   logic       name_truncated;
   logic       last;

   modport source (output valid, output out_kind, output out_byte,
                   output name_truncated, output last, input ready);
   modport sink   (input valid, input out_kind, input out_byte,
                   input name_truncated, input last, output ready);
endinterface

@@ design/esld_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts stream transactions, tracks line and field state,
// writes event name bytes and queues emit/dispatch work. Uses esld_pkg.

module esld_front #(
   parameter int NAME_MAX = esld_pkg::NAME_MAX_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic                 in_kind,
   input  logic [7:0]           in_byte,
   output logic                 push,
   output esld_pkg::cmd_type    push_cmd,
   input  logic                 q_full,
   output esld_pkg::wr_type     wr,
   input  logic                 disp_done
);

   localparam int LW = $clog2(NAME_MAX + 1);
   localparam int NW = esld_pkg::NLEN_W;
   localparam int DW = esld_pkg::DCNT_W;

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;

   localparam logic [2:0] DATA_LEN  = 3'd4;
   localparam logic [2:0] EVENT_LEN = 3'd5;

   typedef enum logic [7:0] {
      M_START   = 8'b0000_0001,
      M_FDATA   = 8'b0000_0010,
      M_FEVENT  = 8'b0000_0100,
      M_SKIP    = 8'b0000_1000,
      M_VDATA0  = 8'b0001_0000,
      M_VDATA   = 8'b0010_0000,
      M_VEVENT0 = 8'b0100_0000,
      M_VEVENT  = 8'b1000_0000
   } mode_type;

   typedef struct packed {
      mode_type        mode;
      logic [2:0]      fm;
      logic            seen;
      logic [LW-1:0]   nlen;
      logic            novf;
   } fst_type;

   typedef struct packed {
      fst_type         st;
      logic            emit;
      logic [7:0]      ebyte;
      logic            wr;
      logic [LW-1:0]   waddr;
      logic [7:0]      wbyte;
      logic            disp;
      logic [LW-1:0]   dlen;
      logic            dovf;
   } step_type;

   localparam fst_type ST_RESET = '{mode: M_START, fm: 3'd0, seen: 1'b0,
                                    nlen: '0, novf: 1'b0};

   function automatic logic [7:0] data_char(input logic [1:0] i);
      logic [7:0] c;
      case (i)
         2'd0:    c = 8'h64;
         2'd1:    c = 8'h61;
         2'd2:    c = 8'h74;
         default: c = 8'h61;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] event_char(input logic [2:0] i);
      logic [7:0] c;
      case (i)
         3'd0:    c = 8'h65;
         3'd1:    c = 8'h76;
         3'd2:    c = 8'h65;
         3'd3:    c = 8'h6E;
         3'd4:    c = 8'h74;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic step_type idle_fn(input fst_type s);
      step_type r;
      r    = '0;
      r.st = s;
      return r;
   endfunction

   // one ordinary (non line ending) byte
   function automatic step_type ord_fn(input fst_type s, input logic [7:0] b);
      step_type r;
      r    = '0;
      r.st = s;
      unique case (s.mode)
         M_START: begin
            r.st.fm = 3'd1;
            if (b == data_char(2'd0)) begin
               r.st.mode = M_FDATA;
            end else if (b == event_char(3'd0)) begin
               r.st.mode = M_FEVENT;
            end else begin
               r.st.mode = M_SKIP;
            end
         end
         M_FDATA: begin
            if (b == CH_COLON) begin
               if (s.fm == DATA_LEN) begin
                  r.emit    = s.seen;
                  r.ebyte   = CH_LF;
                  r.st.seen = 1'b1;
                  r.st.mode = M_VDATA0;
               end else begin
                  r.st.mode = M_SKIP;
               end
            end else if (s.fm < DATA_LEN && b == data_char(s.fm[1:0])) begin
               r.st.fm = s.fm + 3'd1;
            end else begin
               r.st.mode = M_SKIP;
            end
         end
         M_FEVENT: begin
            if (b == CH_COLON) begin
               if (s.fm == EVENT_LEN) begin
                  r.st.nlen = '0;
                  r.st.novf = 1'b0;
                  r.st.mode = M_VEVENT0;
               end else begin
                  r.st.mode = M_SKIP;
               end
            end else if (s.fm < EVENT_LEN && b == event_char(s.fm)) begin
               r.st.fm = s.fm + 3'd1;
            end else begin
               r.st.mode = M_SKIP;
            end
         end
         M_VDATA0: begin
            r.st.mode = M_VDATA;
            r.emit    = (b != CH_SPACE);
            r.ebyte   = b;
         end
         M_VDATA: begin
            r.emit  = 1'b1;
            r.ebyte = b;
         end
         M_VEVENT0, M_VEVENT: begin
            r.st.mode = M_VEVENT;
            if (s.mode == M_VEVENT || b != CH_SPACE) begin
               if (s.nlen < LW'(NAME_MAX)) begin
                  r.wr      = 1'b1;
                  r.waddr   = s.nlen;
                  r.wbyte   = b;
                  r.st.nlen = s.nlen + LW'(1);
               end else begin
                  r.st.novf = 1'b1;
               end
            end
         end
         M_SKIP: begin
         end
         default: begin
            r.st.mode = M_SKIP;
         end
      endcase
      return r;
   endfunction

   // line ending: blank line dispatches, bare field names take effect
   function automatic step_type end_fn(input fst_type s);
      step_type r;
      r    = '0;
      r.st = s;
      if (s.mode == M_START) begin
         r.disp    = s.seen;
         r.dlen    = s.nlen;
         r.dovf    = s.novf;
         r.st.nlen = '0;
         r.st.novf = 1'b0;
         r.st.seen = 1'b0;
      end else if (s.mode == M_FDATA && s.fm == DATA_LEN) begin
         r.emit    = s.seen;
         r.ebyte   = CH_LF;
         r.st.seen = 1'b1;
      end else if (s.mode == M_FEVENT && s.fm == EVENT_LEN) begin
         r.st.nlen = '0;
         r.st.novf = 1'b0;
      end
      r.st.mode = M_START;
      r.st.fm   = 3'd0;
      return r;
   endfunction

   fst_type          st_ff, st_in;
   logic             cr_ff, cr_in;
   logic             pend_ff, pend_in;
   esld_pkg::wr_type wr2_ff, wr2_in;
   logic [DW-1:0]    dcnt_ff, dcnt_in;

   logic             accept;
   logic             value_of_event;

   assign value_of_event = (st_ff.mode == M_VEVENT0) || (st_ff.mode == M_VEVENT);
   assign in_ready = !q_full && !pend_ff && !(dcnt_ff != '0 && value_of_event);
   assign accept   = in_valid && in_ready;

   always_comb begin
      step_type a;
      step_type c;
      fst_type  t;

      a        = idle_fn(st_ff);
      c        = idle_fn(st_ff);
      t        = st_ff;
      cr_in    = cr_ff;
      push_cmd = '0;

      if (in_kind == esld_pkg::IN_EOS) begin
         if (st_ff.mode != M_START || cr_ff) begin
            a = end_fn(st_ff);
         end
         c = idle_fn(a.st);
         t = a.st;
         // end of stream dispatches pending data even without a blank line
         if (!a.disp && a.st.seen) begin
            a.disp = 1'b1;
            a.dlen = a.st.nlen;
            a.dovf = a.st.novf;
            t.nlen = '0;
            t.novf = 1'b0;
            t.seen = 1'b0;
         end
         t.mode = M_START;
         t.fm   = 3'd0;
         cr_in  = 1'b0;
      end else if (in_byte == CH_LF) begin
         a     = end_fn(st_ff);
         c     = idle_fn(a.st);
         t     = a.st;
         cr_in = 1'b0;
      end else if (in_byte == CH_CR) begin
         if (cr_ff) begin
            a = ord_fn(st_ff, CH_CR);
         end
         c     = idle_fn(a.st);
         t     = a.st;
         cr_in = 1'b1;
      end else begin
         if (cr_ff) begin
            a = ord_fn(st_ff, CH_CR);
         end
         c     = ord_fn(a.st, in_byte);
         t     = c.st;
         cr_in = 1'b0;
      end

      push_cmd.d0_vld = a.emit;
      push_cmd.d0     = a.ebyte;
      push_cmd.d1_vld = c.emit;
      push_cmd.d1     = c.ebyte;
      push_cmd.disp   = a.disp;
      push_cmd.dlen   = NW'(a.dlen);
      push_cmd.dovf   = a.dovf;

      st_in = accept ? t : st_ff;
      if (!accept) begin
         cr_in = cr_ff;
      end

      push = accept && (push_cmd.d0_vld || push_cmd.d1_vld || push_cmd.disp);

      // a held CR plus a name byte gives two writes: hold the second one
      wr      = '0;
      wr2_in  = wr2_ff;
      pend_in = 1'b0;
      if (pend_ff) begin
         wr = wr2_ff;
      end else if (accept) begin
         if (a.wr) begin
            wr.vld  = 1'b1;
            wr.addr = NW'(a.waddr);
            wr.data = a.wbyte;
            if (c.wr) begin
               pend_in     = 1'b1;
               wr2_in.vld  = 1'b1;
               wr2_in.addr = NW'(c.waddr);
               wr2_in.data = c.wbyte;
            end
         end else if (c.wr) begin
            wr.vld  = 1'b1;
            wr.addr = NW'(c.waddr);
            wr.data = c.wbyte;
         end
      end

      dcnt_in = dcnt_ff + DW'(push && push_cmd.disp) - DW'(disp_done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_RESET;
         cr_ff   <= 1'b0;
         pend_ff <= 1'b0;
         dcnt_ff <= '0;
      end else begin
         st_ff   <= st_in;
         cr_ff   <= cr_in;
         pend_ff <= pend_in;
         dcnt_ff <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      wr2_ff <= wr2_in;
   end

   // the name store must not change while a dispatch may still read it
   a_no_write_in_dispatch: assert property (@(posedge clock) disable iff (reset)
      wr.vld |-> dcnt_ff == '0)
      else $error("name store written while a dispatch is outstanding");

   a_dcnt_bound: assert property (@(posedge clock) disable iff (reset)
      dcnt_ff <= DW'(esld_pkg::QUEUE_DEPTH + 1))
      else $error("dispatch count out of range");

   a_pend_one_cycle: assert property (@(posedge clock) disable iff (reset)
      pend_ff |=> !pend_ff)
      else $error("held name write not retired in one cycle");

endmodule

@@ design/esld_queue.sv @@
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
// Uses esld_pkg for the command type and depth.

module esld_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  esld_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output esld_pkg::cmd_type head,
   output logic              empty
);

   localparam int DEPTH = esld_pkg::QUEUE_DEPTH;
   localparam int PW    = esld_pkg::QPTR_W;
   localparam int CW    = esld_pkg::QCNT_W;

   esld_pkg::cmd_type entry_ff [DEPTH];
   logic [PW-1:0]     wptr_ff, wptr_in;
   logic [PW-1:0]     rptr_ff, rptr_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign head    = entry_ff[rptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + PW'(1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + PW'(1);
      end
      cnt_in = cnt_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command pushed into a full queue");

endmodule

@@ design/esld_back.sv @@
`timescale 1ns / 1ps
// Back end: holds the event name store, sequences data bytes, name bytes
// and frame ends into the registered response stage. Uses esld_pkg.

module esld_back #(
   parameter int NAME_MAX = esld_pkg::NAME_MAX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  esld_pkg::wr_type  wr,
   input  logic              q_empty,
   input  esld_pkg::cmd_type q_head,
   output logic              q_pop,
   output logic              disp_done,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [1:0]        out_kind,
   output logic [7:0]        out_byte,
   output logic              out_trunc,
   output logic              out_last
);

   localparam int AW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
   localparam int NW = esld_pkg::NLEN_W;

   typedef enum logic [5:0] {
      PH_IDLE  = 6'b00_0001,
      PH_DATA0 = 6'b00_0010,
      PH_DATA1 = 6'b00_0100,
      PH_READ  = 6'b00_1000,
      PH_NAME  = 6'b01_0000,
      PH_END   = 6'b10_0000
   } phase_type;

   function automatic phase_type tail_phase(input esld_pkg::cmd_type c);
      phase_type p;
      if (!c.disp) begin
         p = PH_IDLE;
      end else if (c.dlen != '0) begin
         p = PH_READ;
      end else begin
         p = PH_END;
      end
      return p;
   endfunction

   logic [7:0]        mem [NAME_MAX];
   logic [7:0]        rd_data_ff;

   phase_type         ph_ff, ph_in;
   esld_pkg::cmd_type cur_ff, cur_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic              ov_ff;
   logic [1:0]        kind_ff, kind_in;
   logic [7:0]        byte_ff, byte_in;
   logic              trunc_ff, trunc_in;
   logic              last_ff, last_in;
   logic              load;
   logic              out_free;

   assign out_free  = !ov_ff || out_ready;
   assign out_valid = ov_ff;
   assign out_kind  = kind_ff;
   assign out_byte  = byte_ff;
   assign out_trunc = trunc_ff;
   assign out_last  = last_ff;

   always_comb begin
      ph_in     = ph_ff;
      cur_in    = cur_ff;
      idx_in    = idx_ff;
      load      = 1'b0;
      kind_in   = kind_ff;
      byte_in   = byte_ff;
      trunc_in  = 1'b0;
      last_in   = 1'b0;
      q_pop     = 1'b0;
      disp_done = 1'b0;

      unique case (ph_ff)
         PH_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cur_in = q_head;
               idx_in = '0;
               if (q_head.d0_vld) begin
                  ph_in = PH_DATA0;
               end else if (q_head.d1_vld) begin
                  ph_in = PH_DATA1;
               end else begin
                  ph_in = tail_phase(q_head);
               end
            end
         end
         PH_DATA0: begin
            if (out_free) begin
               load    = 1'b1;
               kind_in = esld_pkg::OUT_DATA;
               byte_in = cur_ff.d0;
               last_in = !cur_ff.d1_vld && !cur_ff.disp;
               ph_in   = cur_ff.d1_vld ? PH_DATA1 : tail_phase(cur_ff);
            end
         end
         PH_DATA1: begin
            if (out_free) begin
               load    = 1'b1;
               kind_in = esld_pkg::OUT_DATA;
               byte_in = cur_ff.d1;
               last_in = !cur_ff.disp;
               ph_in   = tail_phase(cur_ff);
            end
         end
         PH_READ: begin
            // store read at idx_ff lands in rd_data_ff this edge
            ph_in = PH_NAME;
         end
         PH_NAME: begin
            if (out_free) begin
               load    = 1'b1;
               kind_in = esld_pkg::OUT_NAME;
               byte_in = rd_data_ff;
               idx_in  = idx_ff + AW'(1);
               ph_in   = ((NW'(idx_ff) + NW'(1)) == cur_ff.dlen) ? PH_END : PH_READ;
            end
         end
         PH_END: begin
            if (out_free) begin
               load      = 1'b1;
               kind_in   = esld_pkg::OUT_END;
               byte_in   = 8'h00;
               trunc_in  = cur_ff.dovf;
               last_in   = 1'b1;
               disp_done = 1'b1;
               ph_in     = PH_IDLE;
            end
         end
         default: begin
            ph_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_IDLE;
         ov_ff <= 1'b0;
      end else begin
         ph_ff <= ph_in;
         if (load) begin
            ov_ff <= 1'b1;
         end else if (out_ready) begin
            ov_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      if (load) begin
         kind_ff  <= kind_in;
         byte_ff  <= byte_in;
         trunc_ff <= trunc_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.vld) begin
         mem[wr.addr[AW-1:0]] <= wr.data;
      end
      rd_data_ff <= mem[idx_ff];
   end

   a_name_in_range: assert property (@(posedge clock) disable iff (reset)
      ph_ff == PH_NAME |-> NW'(idx_ff) < cur_ff.dlen)
      else $error("name read beyond stored length");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      disp_done |=> ph_ff == PH_IDLE)
      else $error("sequencer not idle after frame end");

endmodule

@@ design/event_stream_line_decoder.sv @@
`timescale 1ns / 1ps
// Top level of the event stream line decoder: front end, command queue, back end.
// Depends on esld_pkg, esld_ifs, esld_front, esld_queue and esld_back.
//
//   channel   dir  handshake      payload
//   req_bus   in   valid/ready    kind, byte_in
//   rsp_bus   out  valid/ready    out_kind, out_byte, name_truncated, last
//
// The front end takes stream bytes and keeps taking them while the back end
// drains queued work. The back end pops each queued transaction while idle,
// then sends its data bytes, its name bytes (store read, then output register)
// and the frame end. The front end stalls while a dispatch is outstanding and
// the current line is an event value, while the held second name write of a
// transaction that writes two name bytes retires, and while the queue is full.
// Synchronous reset clears control state only; the name store needs no clearing.

module event_stream_line_decoder #(
   parameter int NAME_MAX = esld_pkg::NAME_MAX_DEF
) (
   input logic              clock,
   input logic              reset,
   esld_req_if.sink         req_bus,
   esld_rsp_if.source       rsp_bus
);

   esld_pkg::cmd_type push_cmd;
   esld_pkg::cmd_type head;
   esld_pkg::wr_type  wr;
   logic              push, full, pop, empty, disp_done;

   esld_front #(.NAME_MAX(NAME_MAX)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_kind   (req_bus.kind),
      .in_byte   (req_bus.byte_in),
      .push      (push),
      .push_cmd  (push_cmd),
      .q_full    (full),
      .wr        (wr),
      .disp_done (disp_done)
   );

   esld_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .head     (head),
      .empty    (empty)
   );

   esld_back #(.NAME_MAX(NAME_MAX)) u_back (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .q_empty   (empty),
      .q_head    (head),
      .q_pop     (pop),
      .disp_done (disp_done),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_kind  (rsp_bus.out_kind),
      .out_byte  (rsp_bus.out_byte),
      .out_trunc (rsp_bus.name_truncated),
      .out_last  (rsp_bus.last)
   );

endmodule

@@ verif/esld_line_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the event stream line decoder: predicts response transactions
// from accepted request transactions and compares them. Depends on esld_pkg, esld_ifs.

module esld_line_checker #(
   parameter int NAME_MAX = esld_pkg::NAME_MAX_DEF
) (
   input  logic clock,
   input  logic reset,
   esld_req_if  req_mon,
   esld_rsp_if  rsp_mon,
   output int   fail_count,
   output int   outstanding,
   output int   results_seen,
   output int   frames_seen,
   output int   truncated_seen
);

   typedef enum logic [2:0] {
      LM_START, LM_FDATA, LM_FEVENT, LM_SKIP,
      LM_VDATA0, LM_VDATA, LM_VEVENT0, LM_VEVENT
   } line_mode_type;

   typedef struct packed {
      esld_pkg::out_kind_type kind;
      logic [7:0]             value;
      logic                   trunc;
      logic                   last;
   } rsp_item_type;

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [0:3][7:0] WORD_DATA  = "data";
   localparam logic [0:4][7:0] WORD_EVENT = "event";

   line_mode_type mode;
   int unsigned   matched;
   bit            cr_held;
   bit            data_open;
   logic [7:0]    name_mem [NAME_MAX];
   int unsigned   name_len;
   bit            name_cut;
   rsp_item_type  due_results [$];
   int            errors, n_results, n_frames, n_trunc;

   function void owe(esld_pkg::out_kind_type k, logic [7:0] b, logic t);
      rsp_item_type item;
      item = '{kind: k, value: b, trunc: t, last: 1'b0};
      due_results.insert(due_results.size(), item);
   endfunction

   function void store_name_byte(logic [7:0] b);
      if (name_len < NAME_MAX) begin
         name_mem[name_len] = b;
         name_len++;
      end else begin
         name_cut = 1'b1;
      end
   endfunction

   // join successive data lines of one frame with LF
   function void open_data_line();
      if (data_open) owe(esld_pkg::OUT_DATA, CH_LF, 1'b0);
      data_open = 1'b1;
   endfunction

   function void dispatch_frame();
      for (int i = 0; i < name_len; i++) owe(esld_pkg::OUT_NAME, name_mem[i], 1'b0);
      owe(esld_pkg::OUT_END, 8'h00, name_cut);
      name_len  = 0;
      name_cut  = 1'b0;
      data_open = 1'b0;
   endfunction

   function void decode_byte(logic [7:0] b);
      case (mode)
         LM_START: begin
            matched = 1;
            if (b == CH_COLON) mode = LM_SKIP;
            else if (b == WORD_DATA[0]) mode = LM_FDATA;
            else if (b == WORD_EVENT[0]) mode = LM_FEVENT;
            else mode = LM_SKIP;
         end
         LM_FDATA: begin
            if (b == CH_COLON) begin
               if (matched == 4) begin
                  open_data_line();
                  mode = LM_VDATA0;
               end else begin
                  mode = LM_SKIP;
               end
            end else if (matched < 4 && b == WORD_DATA[matched]) begin
               matched++;
            end else begin
               mode = LM_SKIP;
            end
         end
         LM_FEVENT: begin
            if (b == CH_COLON) begin
               if (matched == 5) begin
                  name_len = 0;
                  name_cut = 1'b0;
                  mode     = LM_VEVENT0;
               end else begin
                  mode = LM_SKIP;
               end
            end else if (matched < 5 && b == WORD_EVENT[matched]) begin
               matched++;
            end else begin
               mode = LM_SKIP;
            end
         end
         LM_VDATA0: begin
            mode = LM_VDATA;
            if (b != CH_SPACE) owe(esld_pkg::OUT_DATA, b, 1'b0);
         end
         LM_VDATA: owe(esld_pkg::OUT_DATA, b, 1'b0);
         LM_VEVENT0: begin
            mode = LM_VEVENT;
            if (b != CH_SPACE) store_name_byte(b);
         end
         LM_VEVENT: store_name_byte(b);
         default: ;
      endcase
   endfunction

   function void close_line();
      if (mode == LM_START) begin
         if (data_open) dispatch_frame();
         name_len  = 0;
         name_cut  = 1'b0;
         data_open = 1'b0;
      end else if (mode == LM_FDATA && matched == 4) begin
         open_data_line();
      end else if (mode == LM_FEVENT && matched == 5) begin
         name_len = 0;
         name_cut = 1'b0;
      end
      mode    = LM_START;
      matched = 0;
      cr_held = 1'b0;
   endfunction

   function void decode_item(esld_pkg::in_kind_type k, logic [7:0] b);
      int prior;
      prior = due_results.size();
      if (k == esld_pkg::IN_EOS) begin
         if (mode != LM_START || cr_held) close_line();
         if (data_open) dispatch_frame();
         mode    = LM_START;
         matched = 0;
         cr_held = 1'b0;
      end else if (b == CH_LF) begin
         close_line();
      end else if (b == CH_CR) begin
         // hold a CR until we know whether LF follows
         if (cr_held) decode_byte(CH_CR);
         cr_held = 1'b1;
      end else begin
         if (cr_held) decode_byte(CH_CR);
         cr_held = 1'b0;
         decode_byte(b);
      end
      if (due_results.size() > prior) due_results[due_results.size() - 1].last = 1'b1;
   endfunction

   function void check_field(string field, logic [7:0] want_v, logic [7:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0d, got %0d", field, want_v, got_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         mode      = LM_START;
         matched   = 0;
         cr_held   = 1'b0;
         data_open = 1'b0;
         name_len  = 0;
         name_cut  = 1'b0;
         due_results.delete();
         errors    = 0;
         n_results = 0;
         n_frames  = 0;
         n_trunc   = 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            decode_item(esld_pkg::in_kind_type'(req_mon.kind), req_mon.byte_in);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_results.size() == 0) begin
               $error("unexpected result: out_kind %0d, out_byte %0d",
                      rsp_mon.out_kind, rsp_mon.out_byte);
               errors++;
            end else begin
               want = due_results.pop_front();
               n_results++;
               if (want.kind == esld_pkg::OUT_END) begin
                  n_frames++;
                  if (want.trunc) n_trunc++;
               end
               check_field("out_kind", 8'(want.kind), 8'(rsp_mon.out_kind));
               check_field("out_byte", want.value, rsp_mon.out_byte);
               check_field("name_truncated", 8'(want.trunc), 8'(rsp_mon.name_truncated));
               check_field("last", 8'(want.last), 8'(rsp_mon.last));
            end
         end
      end
      fail_count     <= errors;
      outstanding    <= due_results.size();
      results_seen   <= n_results;
      frames_seen    <= n_frames;
      truncated_seen <= n_trunc;
   end

endmodule

@@ verif/tb_event_stream_line_decoder.sv @@
`timescale 1ns / 1ps
// Testbench top for the event stream line decoder: clock, reset, stimulus and verdict.
// Depends on esld_pkg, esld_ifs, event_stream_line_decoder and esld_line_checker.

module tb_event_stream_line_decoder;

   localparam int         RANDOM_ITEMS = 460;
   localparam int         NAME_MAX     = esld_pkg::NAME_MAX_DEF;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;

   logic clock = 1'b0;
   logic reset;

   int chk_fails, chk_outstanding, chk_results, chk_frames, chk_truncated;
   int sent_items, directed_items;
   int send_left, take_left;
   bit send_quiet, take_quiet;

   string other_fields [6] = '{"id", "retry", "dat", "datax", "even", "events"};

   esld_req_if req_if ();
   esld_rsp_if rsp_if ();

   event_stream_line_decoder uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   esld_line_checker #(.NAME_MAX(NAME_MAX)) chk (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .fail_count     (chk_fails),
      .outstanding    (chk_outstanding),
      .results_seen   (chk_results),
      .frames_seen    (chk_frames),
      .truncated_seen (chk_truncated)
   );

   always #1 clock = ~clock;

   initial begin
      #1_500_000;
      $display("simulation failed");
      $finish;
   end

   // draw stretches of random idling or stretches of none at random
   function automatic int draw_gap(inout int left, inout bit quiet);
      if (left == 0) begin
         quiet = ($urandom_range(0, 3) == 0);
         left  = $urandom_range(8, 40);
      end
      left--;
      return quiet ? 0 : $urandom_range(0, 15);
   endfunction

   function automatic logic [7:0] value_byte();
      logic [7:0] b;
      if ($urandom_range(0, 3) == 0) begin
         b = 8'($urandom_range(0, 255));
         if (b == CH_LF) b = CH_CR;
      end else begin
         b = 8'($urandom_range(8'h20, 8'h7E));
      end
      return b;
   endfunction

   task automatic send_item(esld_pkg::in_kind_type k, logic [7:0] b);
      int gap;
      gap = draw_gap(send_left, send_quiet);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.kind    <= k;
      req_if.byte_in <= b;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      sent_items++;
   endtask

   task automatic put_text(string s);
      for (int i = 0; i < s.len(); i++) send_item(esld_pkg::IN_BYTE, s[i]);
   endtask

   task automatic put_eol();
      if ($urandom_range(0, 2) == 0) send_item(esld_pkg::IN_BYTE, CH_CR);
      send_item(esld_pkg::IN_BYTE, CH_LF);
   endtask

   task automatic put_value(int len);
      if ($urandom_range(0, 2) != 0) send_item(esld_pkg::IN_BYTE, CH_SPACE);
      repeat (len) send_item(esld_pkg::IN_BYTE, value_byte());
   endtask

   // a well-formed frame with random content, ended by a blank line or end of stream
   task automatic make_frame();
      int lines, pick, len;
      bit by_eos;
      lines  = $urandom_range(1, 4);
      by_eos = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < lines; i++) begin
         pick = $urandom_range(0, 9);
         if (pick <= 4) begin
            put_text("data");
            if ($urandom_range(0, 5) != 0) begin
               send_item(esld_pkg::IN_BYTE, CH_COLON);
               put_value($urandom_range(0, 8));
            end
         end else if (pick <= 6) begin
            put_text("event");
            if ($urandom_range(0, 5) != 0) begin
               send_item(esld_pkg::IN_BYTE, CH_COLON);
               if ($urandom_range(0, 3) == 0) len = $urandom_range(NAME_MAX + 1, NAME_MAX + 8);
               else len = $urandom_range(0, NAME_MAX);
               put_value(len);
            end
         end else begin
            if (pick == 7) send_item(esld_pkg::IN_BYTE, CH_COLON);
            else put_text(other_fields[$urandom_range(0, 5)]);
            if ($urandom_range(0, 1) == 0) send_item(esld_pkg::IN_BYTE, CH_COLON);
            repeat ($urandom_range(0, 6)) send_item(esld_pkg::IN_BYTE, value_byte());
         end
         // leave the last line open (or a lone CR) when end of stream closes it
         if (i < lines - 1 || !by_eos) put_eol();
         else if ($urandom_range(0, 1) == 0) send_item(esld_pkg::IN_BYTE, CH_CR);
      end
      if (by_eos) send_item(esld_pkg::IN_EOS, 8'($urandom_range(0, 255)));
      else put_eol();
   endtask

   task automatic make_noise();
      repeat ($urandom_range(1, 12)) begin
         case ($urandom_range(0, 9))
            0:       send_item(esld_pkg::IN_EOS, 8'($urandom_range(0, 255)));
            1, 2:    send_item(esld_pkg::IN_BYTE, CH_LF);
            default: send_item(esld_pkg::IN_BYTE, 8'($urandom_range(0, 255)));
         endcase
      end
   endtask

   initial begin
      rsp_if.ready <= 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         int gap;
         gap = draw_gap(take_left, take_quiet);
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         @(negedge clock);
      end
   end

   initial begin
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.kind    <= esld_pkg::IN_BYTE;
      req_if.byte_in <= 8'h00;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty data line, then a blank CR LF line dispatches a bare frame
      put_text("data");
      send_item(esld_pkg::IN_BYTE, CH_LF);
      send_item(esld_pkg::IN_BYTE, CH_CR);
      send_item(esld_pkg::IN_BYTE, CH_LF);
      // NUL, 0xFF and an inner CR pass as data; end of stream drops the held CR
      put_text("data: ");
      send_item(esld_pkg::IN_BYTE, 8'h00);
      send_item(esld_pkg::IN_BYTE, 8'hFF);
      send_item(esld_pkg::IN_BYTE, CH_CR);
      send_item(esld_pkg::IN_BYTE, CH_CR);
      send_item(esld_pkg::IN_EOS, 8'hFF);
      // bare event field clears the name
      put_text("event");
      send_item(esld_pkg::IN_BYTE, CH_LF);
      // lone CR closed by end of stream, nothing to dispatch
      send_item(esld_pkg::IN_BYTE, CH_CR);
      send_item(esld_pkg::IN_EOS, 8'h00);
      directed_items = sent_items;

      while (sent_items - directed_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 6) == 0) make_noise();
         else make_frame();
      end
      req_if.valid <= 1'b0;

      while (chk_outstanding != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Sent %0d request transactions; checked %0d results in %0d frames,",
               sent_items, chk_results, chk_frames);
      $display("%0d of them with a truncated event name.", chk_truncated);
      if (chk_fails == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/esld_pkg.sv
design/esld_ifs.sv
design/esld_front.sv
design/esld_queue.sv
design/esld_back.sv
design/event_stream_line_decoder.sv
verif/esld_line_checker.sv
verif/tb_event_stream_line_decoder.sv
